FILE: rtl/mpg_pkg.sv
// Shared types and constants for the three-axis rotary position generator.
package mpg_pkg;

  // Token modality codes.
  localparam logic TOKEN_TEXT  = 1'b0;
  localparam logic TOKEN_IMAGE = 1'b1;

  // Result error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_RUN_LENGTH = 2'd1;
  localparam logic [1:0] ERR_RUN_COUNT  = 2'd2;

  // Configuration register indexes (word address paddr[3:2]).
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_RUNS  = 2'd2;

  // Widths and reset values.
  localparam int unsigned PosW  = 12;
  localparam int unsigned GridW = 6;
  localparam int unsigned SideW = 7;
  localparam int unsigned CellW = 13;
  localparam int unsigned AddrW = 4;
  localparam logic [SideW-1:0] GRID_HEIGHT_RST = 7'd24;
  localparam logic [SideW-1:0] GRID_WIDTH_RST  = 7'd42;
  localparam logic [SideW-1:0] SIDE_MAX        = 7'd64;

  // One result word.
  typedef struct packed {
    logic [PosW-1:0] temporal_pos;
    logic [PosW-1:0] height_pos;
    logic [PosW-1:0] width_pos;
    logic [1:0]      error_code;
    logic [PosW-1:0] next_position;
    logic            out_last;
  } mpg_result_t;

  // Clamp a grid register into the range 1..64.
  function automatic logic [SideW-1:0] grid_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) r = SideW'(1);
    else if (v > SIDE_MAX) r = SIDE_MAX;
    return r;
  endfunction

endpackage

FILE: rtl/mpg_out_buf.sv
// Result register with a skid stage for the output channel.
module mpg_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mpg_pkg::mpg_result_t push_data_i,
  output logic                push_stall_o,
  output logic                out_valid_o,
  output mpg_pkg::mpg_result_t out_data_o,
  input  logic                out_stall_i
);
  import mpg_pkg::*;

  logic        main_valid_q, skid_valid_q;
  mpg_result_t main_data_q, skid_data_q;
  logic        push, pop;

  // The skid stage catches a word accepted while the output is stalled.
  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = main_valid_q && !out_stall_i;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (!main_valid_q) begin
      main_valid_q <= push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_data_q <= skid_data_q;
    end else if (push && (pop || !main_valid_q)) begin
      main_data_q <= push_data_i;
    end
    if (push && main_valid_q && !pop) begin
      skid_data_q <= push_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

endmodule

FILE: rtl/mrope_position_generator_core.sv
// Top level of the three-axis rotary position generator.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid_i/in_stall_o| token_is_image_i, seq_last_i
//  output   | out_valid_o/out_stall_i | temporal/height/width_pos_o,
//           |                      | error_code_o, next_position_o, out_last_o
//  config   | APB write/read       | paddr 0/4/8: grid height, grid width, runs
//
// The position state is updated at the edge that accepts a token; the result
// is registered at that edge too, in the output register or, when it holds
// an untaken word, in the skid stage. The output register plus a one-word
// skid stage sustain one token per cycle while the output is not stalled;
// the input stalls only when both hold words. Reset clears all position
// state and both valid flags, and restores the grid registers to 24 by 42.
module mrope_position_generator_core #(
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       token_is_image_i,
  input  logic                       seq_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mpg_pkg::PosW-1:0]   temporal_pos_o,
  output logic [mpg_pkg::PosW-1:0]   height_pos_o,
  output logic [mpg_pkg::PosW-1:0]   width_pos_o,
  output logic [1:0]                 error_code_o,
  output logic [mpg_pkg::PosW-1:0]   next_position_o,
  output logic                       out_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpg_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mpg_pkg::*;

  localparam int unsigned RlW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CmpW = (RlW > CellW) ? RlW : CellW;

  // Configuration registers.
  logic [SideW-1:0] grid_height_q, grid_width_q;
  logic [1:0]       image_runs_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_height_q <= GRID_HEIGHT_RST;
      grid_width_q  <= GRID_WIDTH_RST;
      image_runs_q  <= 2'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_GRID_HEIGHT: grid_height_q <= pwdata[SideW-1:0];
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[SideW-1:0];
        REG_IMAGE_RUNS:  image_runs_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      REG_GRID_HEIGHT: prdata = {25'd0, grid_height_q};
      REG_GRID_WIDTH:  prdata = {25'd0, grid_width_q};
      REG_IMAGE_RUNS:  prdata = {30'd0, image_runs_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Grid geometry derived from the registers.
  logic [SideW-1:0] rows, cols, advance;
  logic [CellW-1:0] cells;

  assign rows    = grid_side(grid_height_q);
  assign cols    = grid_side(grid_width_q);
  assign cells   = CellW'(rows) * CellW'(cols);
  assign advance = (rows > cols) ? rows : cols;

  // Position state.
  logic [PosW-1:0]  base_q, base_d;
  logic             in_run_q, in_run_d;
  logic [RlW-1:0]   run_len_q, run_len_d;
  logic [GridW-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]       run_cnt_q, run_cnt_d;
  mpg_result_t      res;
  logic             accept;

  // Per-token update: grid walk for image tokens, run close and sequence end.
  always_comb begin
    logic [CmpW-1:0]  len_x, cells_x;
    logic [SideW-1:0] col_inc;
    logic             bad;
    len_x   = '0;
    cells_x = CmpW'(cells);
    col_inc = '0;
    bad     = 1'b0;
    base_d    = base_q;
    in_run_d  = in_run_q;
    run_len_d = run_len_q;
    row_d     = row_q;
    col_d     = col_q;
    run_cnt_d = run_cnt_q;
    res       = '0;
    res.out_last = seq_last_i;

    if (token_is_image_i == TOKEN_IMAGE) begin
      // A fresh run starts at grid cell zero.
      if (!in_run_q) begin
        run_len_d = '0;
        row_d     = '0;
        col_d     = '0;
      end
      in_run_d = 1'b1;
      res.temporal_pos = base_q;
      res.height_pos   = base_q + PosW'(row_d);
      res.width_pos    = base_q + PosW'(col_d);
      len_x = CmpW'(run_len_d);
      if (len_x < cells_x) begin
        if (len_x + CmpW'(1) < cells_x) begin
          col_inc = SideW'(col_d) + SideW'(1);
          if (col_inc >= cols) begin
            col_d = '0;
            row_d = row_d + GridW'(1);
          end else begin
            col_d = col_inc[GridW-1:0];
          end
        end
      end else begin
        bad = 1'b1;
      end
      if (run_len_d < RlW'(MAX_ROWS)) run_len_d = run_len_d + RlW'(1);
    end else begin
      // A text token closes any open run before taking its position.
      if (in_run_q) begin
        if (CmpW'(run_len_q) != cells_x) bad = 1'b1;
        base_d = base_d + PosW'(advance);
        if (run_cnt_d != 2'd3) run_cnt_d = run_cnt_d + 2'd1;
        in_run_d  = 1'b0;
        run_len_d = '0;
        row_d     = '0;
        col_d     = '0;
      end
      res.temporal_pos = base_d;
      res.height_pos   = base_d;
      res.width_pos    = base_d;
      base_d = base_d + PosW'(1);
    end

    // Sequence end: close the run, check the run count, return to reset.
    if (seq_last_i) begin
      if (in_run_d) begin
        if (CmpW'(run_len_d) != cells_x) bad = 1'b1;
        base_d = base_d + PosW'(advance);
        if (run_cnt_d != 2'd3) run_cnt_d = run_cnt_d + 2'd1;
      end
      res.next_position = base_d;
      if (!bad && run_cnt_d != image_runs_q) res.error_code = ERR_RUN_COUNT;
      base_d    = '0;
      in_run_d  = 1'b0;
      run_len_d = '0;
      row_d     = '0;
      col_d     = '0;
      run_cnt_d = '0;
    end
    if (bad) res.error_code = ERR_RUN_LENGTH;
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      in_run_q  <= 1'b0;
      run_len_q <= '0;
      row_q     <= '0;
      col_q     <= '0;
      run_cnt_q <= '0;
    end else if (accept) begin
      base_q    <= base_d;
      in_run_q  <= in_run_d;
      run_len_q <= run_len_d;
      row_q     <= row_d;
      col_q     <= col_d;
      run_cnt_q <= run_cnt_d;
    end
  end

  // Result register and skid stage.
  mpg_result_t out_word;

  mpg_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_data_i  (res),
    .push_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_word),
    .out_stall_i  (out_stall_i)
  );

  assign temporal_pos_o  = out_word.temporal_pos;
  assign height_pos_o    = out_word.height_pos;
  assign width_pos_o     = out_word.width_pos;
  assign error_code_o    = out_word.error_code;
  assign next_position_o = out_word.next_position;
  assign out_last_o      = out_word.out_last;

endmodule
